// File: design/dstf_pkg.sv
// Shared types and constants for the SMTP lone-dot line stuffer.
`default_nettype none
package dstf_pkg;

   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;

   // Result bytes one request may cause, and queue sizing.
   localparam int unsigned GRP_BYTES   = 4;
   localparam int unsigned GRP_IDX_W   = 2;
   localparam int unsigned GRP_CNT_W   = 3;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_IDX_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_MID   = 3'd1,
      PH_D1    = 3'd2,
      PH_D2    = 3'd3,
      PH_D1CR  = 3'd4,
      PH_D2CR  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       body_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       out_body_end;
   } rsp_payload_type;

   // Bytes released by one request, first byte in entry 0.
   typedef struct packed {
      logic [GRP_BYTES-1:0][7:0] bytes;
      logic [GRP_CNT_W-1:0]      count;
      logic                      body_end;
   } grp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// File: design/smtp_lone_dot_line_stuffer_unit.sv
// Top level of the SMTP lone-dot line stuffer.
//
// Usage:
//   req_* carries one body byte per request plus a body_end flag. A request is
//   taken at a clock edge with req_valid high and req_stall low.
//   rsp_* carries the transcoded bytes, one per response, under the same
//   valid/stall rule. run_end marks the last response of a request and
//   out_body_end the last byte of a body. A request whose bytes are held back
//   (a possible dot line) gives no response until it resolves.
//   csr_* writes decode_mode (0 stuffs lone-dot lines, 1 unstuffs double-dot
//   lines). csr_ready is always high; write only while the block is idle.
// Timing:
//   The first response of a request is registered in the queue and then in the
//   response register, which loads it from the queue head once it is queued.
//   The front end takes one request per cycle unless the queue is full; the
//   response register emits one byte per cycle while rsp_stall is low, so a
//   request that releases several bytes holds the output for each in turn.
//   A four-group queue absorbs that expansion; req_stall rises only when the queue is full.
// Reset:
//   Synchronous, active high: line-start state, empty queue, no response
//   valid, decode_mode back to 0. A stalled response holds its byte and flags.
`default_nettype none
module smtp_lone_dot_line_stuffer_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dstf_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dstf_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);

   logic                       decode_mode_ff, decode_mode_in;
   logic                       push;
   logic                       pop;
   dstf_pkg::grp_type          push_grp;
   dstf_pkg::grp_type          head_grp;
   dstf_pkg::queue_status_type q_status;

   // Config register: always ready, take the write on valid.
   assign csr_ready      = 1'b1;
   assign decode_mode_in = (csr_valid && csr_ready) ? csr_data : decode_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
      end else begin
         decode_mode_ff <= decode_mode_in;
      end
   end

   // Classify each request and queue the bytes it releases.
   dstf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .decode_mode (decode_mode_ff),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .q_status    (q_status),
      .req_stall   (req_stall),
      .push        (push),
      .push_grp    (push_grp)
   );

   // Hold groups so the front end keeps running while the output is busy.
   dstf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .pop      (pop),
      .head_grp (head_grp),
      .status   (q_status)
   );

   // Serialize the head group into the response register.
   dstf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_grp  (head_grp),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: design/dstf_front.sv
// Front end: accepts requests, tracks line-start matching, builds byte groups.
`default_nettype none
module dstf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      decode_mode,
   input  logic                      req_valid,
   input  dstf_pkg::req_payload_type req_data,
   input  dstf_pkg::queue_status_type q_status,
   output logic                      req_stall,
   output logic                      push,
   output dstf_pkg::grp_type         push_grp
);

   dstf_pkg::phase_type phase_ff, phase_in;
   logic                last_cr_ff, last_cr_in;
   logic                accept;
   logic [7:0]          b;
   logic                e;
   logic                is_dot, is_cr, is_lf;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign b         = req_data.data_byte;
   assign e         = req_data.body_end;
   assign is_dot    = (b == dstf_pkg::CH_DOT);
   assign is_cr     = (b == dstf_pkg::CH_CR);
   assign is_lf     = (b == dstf_pkg::CH_LF);

   // Next state.
   always_comb begin
      dstf_pkg::phase_type mid_phase;
      logic                mid_cr;
      logic                pass_prev_cr;
      logic                pass;
      mid_phase    = phase_ff;
      mid_cr       = last_cr_ff;
      pass_prev_cr = last_cr_ff;
      pass         = 1'b0;
      case (phase_ff)
         dstf_pkg::PH_START: begin
            if (is_dot) begin
               mid_phase = dstf_pkg::PH_D1;
               mid_cr    = 1'b0;
            end else begin
               pass = 1'b1;
            end
         end
         dstf_pkg::PH_D1: begin
            if (!decode_mode && is_cr) begin
               mid_phase = dstf_pkg::PH_D1CR;
            end else if (decode_mode && is_dot) begin
               mid_phase = dstf_pkg::PH_D2;
            end else begin
               pass         = 1'b1;
               pass_prev_cr = 1'b0;
            end
         end
         dstf_pkg::PH_D1CR: begin
            if (is_lf) begin
               mid_phase = dstf_pkg::PH_START;
               mid_cr    = 1'b0;
            end else begin
               pass         = 1'b1;
               pass_prev_cr = 1'b1;
            end
         end
         dstf_pkg::PH_D2: begin
            if (is_cr) begin
               mid_phase = dstf_pkg::PH_D2CR;
            end else begin
               pass         = 1'b1;
               pass_prev_cr = 1'b0;
            end
         end
         dstf_pkg::PH_D2CR: begin
            if (is_lf) begin
               mid_phase = dstf_pkg::PH_START;
               mid_cr    = 1'b0;
            end else begin
               pass         = 1'b1;
               pass_prev_cr = 1'b1;
            end
         end
         default: begin
            pass = 1'b1;
         end
      endcase
      if (pass) begin
         mid_phase = (pass_prev_cr && is_lf) ? dstf_pkg::PH_START : dstf_pkg::PH_MID;
         mid_cr    = is_cr;
      end
      if (e) begin
         mid_phase = dstf_pkg::PH_START;
         mid_cr    = 1'b0;
      end
      phase_in   = accept ? mid_phase : phase_ff;
      last_cr_in = accept ? mid_cr : last_cr_ff;
   end

   // Outputs: the group of bytes this request releases.
   always_comb begin
      push_grp          = '0;
      push_grp.body_end = e;
      case (phase_ff)
         dstf_pkg::PH_START: begin
            if (is_dot) begin
               push_grp.bytes[0] = dstf_pkg::CH_DOT;
               push_grp.count    = e ? 3'd1 : 3'd0;
            end else begin
               push_grp.bytes[0] = b;
               push_grp.count    = 3'd1;
            end
         end
         dstf_pkg::PH_D1: begin
            if ((!decode_mode && is_cr) || (decode_mode && is_dot)) begin
               push_grp.bytes[0] = dstf_pkg::CH_DOT;
               push_grp.bytes[1] = decode_mode ? dstf_pkg::CH_DOT : dstf_pkg::CH_CR;
               push_grp.count    = e ? 3'd2 : 3'd0;
            end else begin
               push_grp.bytes[0] = dstf_pkg::CH_DOT;
               push_grp.bytes[1] = b;
               push_grp.count    = 3'd2;
            end
         end
         dstf_pkg::PH_D1CR: begin
            push_grp.bytes[0] = dstf_pkg::CH_DOT;
            if (is_lf) begin
               push_grp.bytes[1] = dstf_pkg::CH_DOT;
               push_grp.bytes[2] = dstf_pkg::CH_CR;
               push_grp.bytes[3] = dstf_pkg::CH_LF;
               push_grp.count    = 3'd4;
            end else begin
               push_grp.bytes[1] = dstf_pkg::CH_CR;
               push_grp.bytes[2] = b;
               push_grp.count    = 3'd3;
            end
         end
         dstf_pkg::PH_D2: begin
            push_grp.bytes[0] = dstf_pkg::CH_DOT;
            push_grp.bytes[1] = dstf_pkg::CH_DOT;
            if (is_cr) begin
               push_grp.bytes[2] = dstf_pkg::CH_CR;
               push_grp.count    = e ? 3'd3 : 3'd0;
            end else begin
               push_grp.bytes[2] = b;
               push_grp.count    = 3'd3;
            end
         end
         dstf_pkg::PH_D2CR: begin
            push_grp.bytes[0] = dstf_pkg::CH_DOT;
            if (is_lf) begin
               push_grp.bytes[1] = dstf_pkg::CH_CR;
               push_grp.bytes[2] = dstf_pkg::CH_LF;
               push_grp.count    = 3'd3;
            end else begin
               push_grp.bytes[1] = dstf_pkg::CH_DOT;
               push_grp.bytes[2] = dstf_pkg::CH_CR;
               push_grp.bytes[3] = b;
               push_grp.count    = 3'd4;
            end
         end
         default: begin
            push_grp.bytes[0] = b;
            push_grp.count    = 3'd1;
         end
      endcase
   end

   assign push = accept && (push_grp.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= dstf_pkg::PH_START;
         last_cr_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         last_cr_ff <= last_cr_in;
      end
   end

endmodule
`default_nettype wire

// File: design/dstf_queue.sv
// Small queue of byte groups between front and back ends.
`default_nettype none
module dstf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dstf_pkg::grp_type          push_grp,
   input  logic                       pop,
   output dstf_pkg::grp_type          head_grp,
   output dstf_pkg::queue_status_type status
);

   dstf_pkg::grp_type                   entry_ff [dstf_pkg::QUEUE_DEPTH];
   logic [dstf_pkg::QUEUE_IDX_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dstf_pkg::QUEUE_IDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dstf_pkg::QUEUE_CNT_W-1:0]    cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == dstf_pkg::QUEUE_CNT_W'(dstf_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head_grp     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_grp;
      end
   end

endmodule
`default_nettype wire

// File: design/dstf_back.sv
// Back end: walks the head group one byte a cycle, while the response is not stalled, into the response register.
`default_nettype none
module dstf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dstf_pkg::grp_type          head_grp,
   input  dstf_pkg::queue_status_type q_status,
   output logic                       pop,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output dstf_pkg::rsp_payload_type  rsp_data
);

   logic [dstf_pkg::GRP_IDX_W-1:0] idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   dstf_pkg::rsp_payload_type      rsp_ff, rsp_in;
   logic                           load;
   logic                           last;

   assign load = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign last = (({1'b0, idx_ff} + 3'd1) == head_grp.count);
   assign pop  = load && last;

   always_comb begin
      rsp_in.out_byte     = head_grp.bytes[idx_ff];
      rsp_in.run_end      = last;
      rsp_in.out_body_end = last && head_grp.body_end;
      idx_in              = idx_ff;
      if (load) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: design/dstf_checker.sv
// Port-level checks for the lone-dot line stuffer, bound to the top level.
`default_nettype none
module dstf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input dstf_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input dstf_pkg::rsp_payload_type rsp_data
);

   // A stalled response holds its byte and flags.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A stalled request holds its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // The body's last byte always closes its request's run.
   a_body_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_body_end |-> rsp_data.run_end)
      else $error("body end without run end");

   // Reset drops any pending response.
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Queue is empty after reset, so requests are taken at once.
   a_reset_stall: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("request stalled right after reset");

endmodule

bind smtp_lone_dot_line_stuffer_unit dstf_checker u_dstf_checker (.*);
`default_nettype wire

// File: tb/tb_smtp_lone_dot_line_stuffer_unit.sv
// Self-checking testbench for the SMTP lone-dot line stuffer: directed and random body bytes.
module tb_smtp_lone_dot_line_stuffer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Stop well past the slowest legal run: ~220 requests, up to four bytes each,
   // each byte waiting out a receiver stall, plus drains between phases.
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   dstf_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   dstf_pkg::rsp_payload_type rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_data = 1'b0;

   smtp_lone_dot_line_stuffer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // Requests waiting to be driven, and the bytes the block owes us, oldest first.
   dstf_pkg::req_payload_type pending_req_q[$];
   dstf_pkg::rsp_payload_type stuffed_q[$];

   // Our own copy of the transcoder state and the mode register.
   dstf_pkg::phase_type line_phase = dstf_pkg::PH_START;
   logic                prev_cr = 1'b0;
   logic                decode_mode_model = 1'b0;
   logic [7:0]          released_q[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned reqs_queued = 0;
   int unsigned reqs_taken = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Pass a byte through: a LF right after a passed CR opens a new line.
   function void pass_byte(input logic [7:0] b);
      released_q.push_back(b);
      line_phase = (prev_cr && b == dstf_pkg::CH_LF) ? dstf_pkg::PH_START
                                                     : dstf_pkg::PH_MID;
      prev_cr    = (b == dstf_pkg::CH_CR);
   endfunction

   // Advance the line matcher by one request and queue the bytes it releases.
   function void transcode_byte(input dstf_pkg::req_payload_type r);
      logic [7:0]                b;
      int                        n;
      dstf_pkg::rsp_payload_type want;
      b = r.data_byte;
      released_q.delete();
      case (line_phase)
         dstf_pkg::PH_START: begin
            // A dot at line start may open a dot line: hold it.
            if (b == dstf_pkg::CH_DOT) begin
               line_phase = dstf_pkg::PH_D1;
               prev_cr    = 1'b0;
            end else begin
               pass_byte(b);
            end
         end
         dstf_pkg::PH_D1: begin
            // One held dot: the mode in force right now picks the rule.
            if (!decode_mode_model && b == dstf_pkg::CH_CR) begin
               line_phase = dstf_pkg::PH_D1CR;
            end else if (decode_mode_model && b == dstf_pkg::CH_DOT) begin
               line_phase = dstf_pkg::PH_D2;
            end else begin
               released_q.push_back(dstf_pkg::CH_DOT);
               prev_cr = 1'b0;
               pass_byte(b);
            end
         end
         dstf_pkg::PH_D1CR: begin
            // Lone dot line complete: stuff it to two dots.
            if (b == dstf_pkg::CH_LF) begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_CR);
               released_q.push_back(dstf_pkg::CH_LF);
               line_phase = dstf_pkg::PH_START;
               prev_cr    = 1'b0;
            end else begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_CR);
               prev_cr = 1'b1;
               pass_byte(b);
            end
         end
         dstf_pkg::PH_D2: begin
            if (b == dstf_pkg::CH_CR) begin
               line_phase = dstf_pkg::PH_D2CR;
            end else begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_DOT);
               prev_cr = 1'b0;
               pass_byte(b);
            end
         end
         dstf_pkg::PH_D2CR: begin
            // Double dot line complete: unstuff it to one dot.
            if (b == dstf_pkg::CH_LF) begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_CR);
               released_q.push_back(dstf_pkg::CH_LF);
               line_phase = dstf_pkg::PH_START;
               prev_cr    = 1'b0;
            end else begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_CR);
               prev_cr = 1'b1;
               pass_byte(b);
            end
         end
         default: begin
            pass_byte(b);
         end
      endcase

      // Body end: flush whatever is held, unchanged, and restart at line start.
      if (r.body_end) begin
         case (line_phase)
            dstf_pkg::PH_D1: begin
               released_q.push_back(dstf_pkg::CH_DOT);
            end
            dstf_pkg::PH_D1CR: begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_CR);
            end
            dstf_pkg::PH_D2: begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_DOT);
            end
            dstf_pkg::PH_D2CR: begin
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_DOT);
               released_q.push_back(dstf_pkg::CH_CR);
            end
            default: begin
            end
         endcase
         line_phase = dstf_pkg::PH_START;
         prev_cr    = 1'b0;
      end

      n = released_q.size();
      if (n > dstf_pkg::GRP_BYTES) n = dstf_pkg::GRP_BYTES;
      for (int k = 0; k < n; k++) begin
         want.out_byte     = released_q[k];
         want.run_end      = (k == n - 1);
         want.out_body_end = (k == n - 1) && r.body_end;
         stuffed_q.push_back(want);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: hold the payload while stalled, advance on acceptance,
   // idle at random between requests.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // Request taken at this edge: predict its bytes now.
         if (req_valid) begin
            transcode_byte(req_data);
            reqs_taken++;
         end
         if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_req_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: stall at random, compare every accepted byte with the
   // oldest expectation, field by field.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      dstf_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (stuffed_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: byte %02h run_end %0b body_end %0b",
                           rsp_data.out_byte, rsp_data.run_end, rsp_data.out_body_end);
            end else begin
               want = stuffed_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.run_end !== want.run_end ||
                   rsp_data.out_body_end !== want.out_body_end) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected byte %02h run_end %0b body_end %0b,",
                               " got byte %02h run_end %0b body_end %0b"},
                              want.out_byte, want.run_end, want.out_body_end,
                              rsp_data.out_byte, rsp_data.run_end, rsp_data.out_body_end);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   task automatic push_req(input logic [7:0] b, input logic e);
      dstf_pkg::req_payload_type r;
      r.data_byte = b;
      r.body_end  = e;
      pending_req_q.push_back(r);
      reqs_queued++;
   endtask

   // Body byte with an occasional body end, so flushes land on every phase.
   task automatic push_body(input logic [7:0] b);
      push_req(b, $urandom_range(19) == 0);
   endtask

   // Wait until every request is taken and every byte has come out, then let
   // any still-held match settle before touching the register.
   task automatic wait_for_drain();
      while (reqs_taken != reqs_queued || stuffed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_decode_mode(input logic m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      decode_mode_model = m;
   endtask

   // One line fragment, mostly well-formed dot lines with random neighbors.
   task automatic queue_random_line();
      int kind;
      int len;
      kind = $urandom_range(11);
      case (kind)
         0, 1: begin
            push_body(dstf_pkg::CH_DOT); push_body(dstf_pkg::CH_CR);
            push_body(dstf_pkg::CH_LF);
         end
         2, 3: begin
            push_body(dstf_pkg::CH_DOT); push_body(dstf_pkg::CH_DOT);
            push_body(dstf_pkg::CH_CR); push_body(dstf_pkg::CH_LF);
         end
         4: begin
            push_body(dstf_pkg::CH_DOT); push_body(dstf_pkg::CH_CR);
            push_body(8'($urandom_range(255)));
         end
         5: begin
            push_body(dstf_pkg::CH_DOT); push_body(dstf_pkg::CH_DOT);
            push_body(dstf_pkg::CH_CR);
            push_body(8'($urandom_range(255)));
         end
         6: begin
            push_body(dstf_pkg::CH_DOT); push_body(8'($urandom_range(255)));
         end
         7: begin
            push_body(dstf_pkg::CH_DOT); push_body(dstf_pkg::CH_DOT);
            push_body(8'($urandom_range(255)));
         end
         8, 9: begin
            len = $urandom_range(1, 5);
            repeat (len) push_body(8'($urandom_range(255)));
            push_body(dstf_pkg::CH_CR); push_body(dstf_pkg::CH_LF);
         end
         10: begin
            push_body(dstf_pkg::CH_DOT); push_body(dstf_pkg::CH_DOT);
            push_body(dstf_pkg::CH_DOT);
            push_body(dstf_pkg::CH_CR); push_body(dstf_pkg::CH_LF);
         end
         default: begin
            // Bare LF or a doubled CR before the line break.
            if ($urandom_range(1)) begin
               push_body(8'($urandom_range(255))); push_body(dstf_pkg::CH_LF);
            end else begin
               push_body(dstf_pkg::CH_CR); push_body(dstf_pkg::CH_CR);
               push_body(dstf_pkg::CH_LF);
            end
         end
      endcase
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned start;
      start = reqs_queued;
      while (reqs_queued - start < count) queue_random_line();
      wait_for_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 48;

      // Encode mode, directed.
      write_decode_mode(1'b0);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_CR, 1'b0);
      push_req(dstf_pkg::CH_LF, 1'b0);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_DOT, 1'b0);
      push_req(dstf_pkg::CH_CR, 1'b0);
      push_req(dstf_pkg::CH_LF, 1'b0);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_CR, 1'b0);
      push_req(8'hFF, 1'b0);
      // Bare LF keeps us inside the line: the dot passes straight through.
      push_req(dstf_pkg::CH_LF, 1'b0); push_req(dstf_pkg::CH_DOT, 1'b0);
      push_req(8'h00, 1'b1);
      push_req(dstf_pkg::CH_DOT, 1'b1);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_CR, 1'b1);
      // Hold one dot, then switch mode under it.
      push_req(dstf_pkg::CH_DOT, 1'b0);
      wait_for_drain();
      write_decode_mode(1'b1);

      // Decode mode, directed.
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_CR, 1'b0);
      push_req(dstf_pkg::CH_LF, 1'b0);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_DOT, 1'b0);
      push_req(dstf_pkg::CH_CR, 1'b0);
      push_req(8'h80, 1'b0);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_DOT, 1'b0);
      push_req(8'h7F, 1'b1);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_DOT, 1'b1);
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_DOT, 1'b0);
      push_req(dstf_pkg::CH_CR, 1'b1);
      // Hold two dots, finish the line in encode mode.
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_DOT, 1'b0);
      wait_for_drain();
      write_decode_mode(1'b0);
      push_req(dstf_pkg::CH_CR, 1'b0); push_req(dstf_pkg::CH_LF, 1'b0);
      // Hold dot and CR in encode mode, finish the line in decode mode.
      push_req(dstf_pkg::CH_DOT, 1'b0); push_req(dstf_pkg::CH_CR, 1'b0);
      wait_for_drain();
      write_decode_mode(1'b1);
      push_req(dstf_pkg::CH_LF, 1'b1);
      wait_for_drain();

      // Random phases: each drain also makes the sender pause for all results.
      write_decode_mode(1'b0);
      run_random(55);

      send_idle_pct = 48;
      recv_idle_pct = 22;
      write_decode_mode(1'b1);
      run_random(55);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_decode_mode(1'b0);
      run_random(25);
      write_decode_mode(1'b1);
      run_random(25);

      if (mismatch_count == 0 && stuffed_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
